// ----- rtl/met_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the Mandelbrot escape-time block.
// No dependencies; every other file imports this package.
package met_pkg;

  // Image size: column and row indexes at or past these limits are clamped.
  localparam int unsigned IMAGE_WIDTH  = 4096;
  localparam int unsigned IMAGE_HEIGHT = 4096;

  localparam int unsigned PIX_W     = 12;  // pixel index width
  localparam int unsigned COORD_W   = 32;  // Q4.28 coordinate register width
  localparam int unsigned STEP_W    = 29;  // pixel spacing width
  localparam int unsigned ITER_W    = 10;  // iteration counter width
  localparam int unsigned RAD_W     = 31;  // escape threshold width
  localparam int unsigned COLOR_W   = 24;  // packed RGB width
  localparam int unsigned CHAN_W    = 8;   // one color channel
  localparam int unsigned FRAC      = 28;  // fraction bits everywhere
  localparam int unsigned Q_W       = 36;  // Q7.28 datapath width
  localparam int unsigned SAT_IN_W  = 44;  // widest sum handed to the saturator
  localparam int unsigned PADDR_W   = 5;   // APB byte address width
  localparam int unsigned APB_DW    = 32;  // APB data width

  typedef logic signed [Q_W-1:0] met_q_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_min;
    logic signed [COORD_W-1:0] y_min;
    logic [STEP_W-1:0]         step_x;
    logic [STEP_W-1:0]         step_y;
    logic [ITER_W-1:0]         max_iter;
    logic [RAD_W-1:0]          esc_rad;
    logic [COLOR_W-1:0]        ext_color;
  } met_cfg_t;

  // The point c of one pixel.
  typedef struct packed {
    met_q_t cx;
    met_q_t cy;
  } met_pt_t;

  // One finished pixel.
  typedef struct packed {
    logic [ITER_W-1:0]  iterations;
    logic               inside_res;
    logic [COLOR_W-1:0] color;
  } met_res_t;

  // Saturate a signed sum to the Q7.28 range.
  function automatic met_q_t met_sat(input logic signed [SAT_IN_W-1:0] v);
    logic [SAT_IN_W-Q_W:0] hi;
    hi = v[SAT_IN_W-1:Q_W-1];
    if ((hi == '0) || (hi == '1)) begin
      return v[Q_W-1:0];
    end else if (v[SAT_IN_W-1]) begin
      return {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      return {1'b0, {(Q_W-1){1'b1}}};
    end
  endfunction

  // Magnitude of a Q7.28 value as an unsigned number (the most negative value maps to 2^35).
  function automatic logic [Q_W-1:0] met_mag(input met_q_t v);
    logic [Q_W-1:0] neg;
    neg = Q_W'(-v);
    return v[Q_W-1] ? neg : Q_W'(v);
  endfunction

endpackage

// ----- rtl/met_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixel requests and pixel results.
// Depends on met_pkg for field widths.
interface met_pixel_if import met_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_col;
  logic [PIX_W-1:0] pixel_row;

  modport source (output valid, pixel_col, pixel_row, input ready);
  modport sink (input valid, pixel_col, pixel_row, output ready);
endinterface

interface met_result_if import met_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ITER_W-1:0] iterations;
  logic              inside_res;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, iterations, inside_res, red, green, blue, input ready);
  modport sink (input valid, iterations, inside_res, red, green, blue, output ready);
endinterface

// ----- rtl/met_setup.sv -----
`timescale 1ns / 1ps
// Three-stage stallable pipeline that maps a pixel index to its point c.
// Depends on met_pkg.
module met_setup import met_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  met_cfg_t         cfg_i,
  input  logic             pix_valid_i,
  output logic             pix_ready_o,
  input  logic [PIX_W-1:0] pix_col_i,
  input  logic [PIX_W-1:0] pix_row_i,
  output logic             pt_valid_o,
  input  logic             pt_take_i,
  output met_pt_t          pt_o
);

  localparam int unsigned PROD_W = PIX_W + STEP_W;

  logic va_q, vb_q, vc_q;
  logic en_a, en_b, en_c;
  logic [PIX_W-1:0] col_cl, row_cl;
  logic [PROD_W-1:0] px_q, py_q;
  met_q_t cxb_q, cyb_q;
  met_pt_t pt_q;
  logic signed [SAT_IN_W-1:0] sum_x, sum_y;
  logic [Q_W-1:0] cy_mag;
  logic [Q_W:0] cy_twice;
  logic cy_small;

  // A stage moves on when it is empty or its successor moves on.
  assign en_c        = !vc_q || pt_take_i;
  assign en_b        = !vb_q || en_c;
  assign en_a        = !va_q || en_b;
  assign pix_ready_o = en_a;

  assign col_cl = (32'(pix_col_i) >= IMAGE_WIDTH) ? PIX_W'(IMAGE_WIDTH - 1) : pix_col_i;
  assign row_cl = (32'(pix_row_i) >= IMAGE_HEIGHT) ? PIX_W'(IMAGE_HEIGHT - 1) : pix_row_i;

  assign sum_x = $signed({{(SAT_IN_W-COORD_W){cfg_i.x_min[COORD_W-1]}}, cfg_i.x_min})
               + $signed({{(SAT_IN_W-PROD_W){1'b0}}, px_q});
  assign sum_y = $signed({{(SAT_IN_W-COORD_W){cfg_i.y_min[COORD_W-1]}}, cfg_i.y_min})
               + $signed({{(SAT_IN_W-PROD_W){1'b0}}, py_q});

  // The imaginary part snaps to the real axis when it lies within half a row of it.
  assign cy_mag   = met_mag(cyb_q);
  assign cy_twice = {cy_mag, 1'b0};
  assign cy_small = cy_twice < (Q_W+1)'(cfg_i.step_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (en_a) va_q <= pix_valid_i;
      if (en_b) vb_q <= va_q;
      if (en_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && pix_valid_i) begin
      px_q <= PROD_W'(col_cl) * PROD_W'(cfg_i.step_x);
      py_q <= PROD_W'(row_cl) * PROD_W'(cfg_i.step_y);
    end
    if (en_b && va_q) begin
      cxb_q <= met_sat(sum_x);
      cyb_q <= met_sat(sum_y);
    end
    if (en_c && vb_q) begin
      pt_q.cx <= cxb_q;
      pt_q.cy <= cy_small ? '0 : cyb_q;
    end
  end

  assign pt_valid_o = vc_q;
  assign pt_o       = pt_q;

endmodule

// ----- rtl/met_iter.sv -----
`timescale 1ns / 1ps
// Three-stage iteration loop for z = z^2 + c, shared by up to three pixels in turn,
// with in-order retirement into an output register. Depends on met_pkg.
module met_iter import met_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  met_cfg_t cfg_i,
  input  logic     pt_valid_i,
  output logic     pt_take_o,
  input  met_pt_t  pt_i,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  output met_res_t res_o
);

  localparam int unsigned MUL_W = 31;  // |z| < 2^30 whenever an iteration runs
  localparam int unsigned SEQ_W = 2;   // three slots need tags modulo four

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic              step;
    met_q_t            cx;
    met_q_t            cy;
    met_q_t            zx;
    met_q_t            zy;
    logic [Q_W-1:0]    zx2;
    logic [Q_W-1:0]    zy2;
    logic [ITER_W-1:0] count;
  } slot_t;

  logic v0_q, v1_q, v2_q, v0_d;
  slot_t s0_q, s0_d, s1_q, s1_d, s2_q, s2_d;
  logic signed [2*MUL_W-1:0] prod0_q, prod0_d;
  met_q_t nzx0_q, nzx0_d;
  logic [MUL_W-1:0] magx1_q, magy1_q;
  logic satx1_q, saty1_q;
  logic [SEQ_W-1:0] wr_seq_q, rd_seq_q;
  logic res_valid_q;
  met_res_t res_q;

  logic [Q_W:0] sum_sq;
  logic done, retire, load, out_free, is_in;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [Q_W+1:0] diff;
  logic signed [SAT_IN_W-1:0] nzy_sum;
  met_q_t zx_n, zy_n;
  logic [Q_W-1:0] magx, magy;
  logic [2*MUL_W-1:0] sqx_full, sqy_full;
  logic [Q_W-1:0] sqx, sqy;

  // Stage 0: bail-out test on the slot coming round, load or retire, zx*zy, new zx.
  assign out_free = !res_valid_q || res_ready_i;
  assign sum_sq   = {1'b0, s2_q.zx2} + {1'b0, s2_q.zy2};
  assign done     = (s2_q.count >= cfg_i.max_iter) || (sum_sq >= (Q_W+1)'(cfg_i.esc_rad));
  assign retire   = v2_q && done && (s2_q.seq == rd_seq_q) && out_free;
  assign load     = !v2_q && pt_valid_i;
  assign pt_take_o = load;
  assign is_in    = s2_q.count == cfg_i.max_iter;

  assign mul_a = s2_q.zx[MUL_W-1:0];
  assign mul_b = s2_q.zy[MUL_W-1:0];
  assign diff  = $signed({2'b00, s2_q.zx2}) - $signed({2'b00, s2_q.zy2})
               + $signed({{2{s2_q.cx[Q_W-1]}}, s2_q.cx});

  always_comb begin
    v0_d    = load || (v2_q && !retire);
    s0_d    = s2_q;
    s0_d.step = v2_q && !done;
    if (load) begin
      s0_d.seq   = wr_seq_q;
      s0_d.step  = 1'b0;
      s0_d.cx    = pt_i.cx;
      s0_d.cy    = pt_i.cy;
      s0_d.zx    = '0;
      s0_d.zy    = '0;
      s0_d.zx2   = '0;
      s0_d.zy2   = '0;
      s0_d.count = '0;
    end
    prod0_d = mul_a * mul_b;
    nzx0_d  = met_sat(SAT_IN_W'(diff));
  end

  // Stage 1: new imaginary part (2*zx*zy floored, plus cy), magnitudes for squaring.
  assign nzy_sum = SAT_IN_W'(prod0_q >>> (FRAC - 1)) + SAT_IN_W'(s0_q.cy);

  always_comb begin
    zx_n = s0_q.zx;
    zy_n = s0_q.zy;
    if (s0_q.step) begin
      zx_n = nzx0_q;
      zy_n = met_sat(nzy_sum);
    end
    s1_d    = s0_q;
    s1_d.zx = zx_n;
    s1_d.zy = zy_n;
    magx    = met_mag(zx_n);
    magy    = met_mag(zy_n);
  end

  // Stage 2: squares, saturated to all ones at or beyond 8.0.
  assign sqx_full = magx1_q * magx1_q;
  assign sqy_full = magy1_q * magy1_q;
  assign sqx = satx1_q ? '1 : Q_W'(sqx_full >> FRAC);
  assign sqy = saty1_q ? '1 : Q_W'(sqy_full >> FRAC);

  always_comb begin
    s2_d = s1_q;
    if (s1_q.step) begin
      s2_d.zx2   = sqx;
      s2_d.zy2   = sqy;
      s2_d.count = s1_q.count + ITER_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      wr_seq_q    <= '0;
      rd_seq_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v0_q;
      v2_q <= v1_q;
      if (load) wr_seq_q <= wr_seq_q + SEQ_W'(1);
      if (retire) begin
        rd_seq_q    <= rd_seq_q + SEQ_W'(1);
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q    <= s0_d;
    prod0_q <= prod0_d;
    nzx0_q  <= nzx0_d;
    s1_q    <= s1_d;
    magx1_q <= magx[MUL_W-1:0];
    magy1_q <= magy[MUL_W-1:0];
    satx1_q <= |magx[Q_W-1:MUL_W];
    saty1_q <= |magy[Q_W-1:MUL_W];
    s2_q    <= s2_d;
    if (retire) begin
      res_q.iterations <= s2_q.count;
      res_q.inside_res <= is_in;
      res_q.color      <= is_in ? '0 : cfg_i.ext_color;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/mandelbrot_escape_time_pixel.sv -----
`timescale 1ns / 1ps
// Top level of the Mandelbrot escape-time pixel evaluator: APB registers and channel glue.
// Depends on met_pkg, met_if, met_setup and met_iter.
//
// Each transaction on pixel_i names one pixel by column and row and yields exactly one
// transaction on result_o, in the same order: the iteration count, an interior flag and
// the pixel color (black inside, the exterior color register outside). A three-stage
// setup pipeline forms c = (x_min + col*step_x, y_min + row*step_y) in Q7.28, snapping
// the imaginary part to zero within half a row of the axis. The escape loop is a
// three-stage ring (cross product, add and saturate, squares) that serves three pixels
// in turn, so each pixel advances one iteration per turn of the ring while the loop as a
// whole does one iteration per cycle when all three slots hold unfinished pixels. A slot
// frees when its pixel retires, and the freed slot takes its next point when it next
// comes round the ring empty. A pixel that finishes early waits in its slot until all
// older pixels have been delivered, and a stalled output holds finished pixels in the
// ring. Registers sit at byte addresses 4*i and should be written only while no pixel
// is in flight; pready is always high.
module mandelbrot_escape_time_pixel import met_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  met_pixel_if.sink          pixel_i,
  met_result_if.source       result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  typedef enum logic [2:0] {
    REG_X_MIN     = 3'd0,
    REG_Y_MIN     = 3'd1,
    REG_STEP_X    = 3'd2,
    REG_STEP_Y    = 3'd3,
    REG_MAX_ITER  = 3'd4,
    REG_ESC_RAD   = 3'd5,
    REG_EXT_COLOR = 3'd6
  } met_reg_e;

  localparam met_cfg_t CFG_RESET = '{
    x_min:     32'hD800_0000,   // -2.5
    y_min:     32'hE000_0000,   // -2.0
    step_x:    29'h004_0000,    // 2^-10
    step_y:    29'h004_0000,
    max_iter:  10'd200,
    esc_rad:   31'h4000_0000,   // 4.0
    ext_color: 24'hFF_FFFF
  };

  met_cfg_t cfg_q, cfg_d;
  logic     wr_en;
  met_reg_e reg_idx;
  logic     st_valid, ld_take;
  met_pt_t  st_pt;
  logic     res_valid;
  met_res_t res;

  // Register file. Writes complete in the access phase; the unused eighth slot is ignored.
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = met_reg_e'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_X_MIN:     cfg_d.x_min     = pwdata;
        REG_Y_MIN:     cfg_d.y_min     = pwdata;
        REG_STEP_X:    cfg_d.step_x    = pwdata[STEP_W-1:0];
        REG_STEP_Y:    cfg_d.step_y    = pwdata[STEP_W-1:0];
        REG_MAX_ITER:  cfg_d.max_iter  = pwdata[ITER_W-1:0];
        REG_ESC_RAD:   cfg_d.esc_rad   = pwdata[RAD_W-1:0];
        REG_EXT_COLOR: cfg_d.ext_color = pwdata[COLOR_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_X_MIN:     prdata = cfg_q.x_min;
      REG_Y_MIN:     prdata = cfg_q.y_min;
      REG_STEP_X:    prdata = APB_DW'(cfg_q.step_x);
      REG_STEP_Y:    prdata = APB_DW'(cfg_q.step_y);
      REG_MAX_ITER:  prdata = APB_DW'(cfg_q.max_iter);
      REG_ESC_RAD:   prdata = APB_DW'(cfg_q.esc_rad);
      REG_EXT_COLOR: prdata = APB_DW'(cfg_q.ext_color);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Point generation feeds the escape loop whenever an empty slot comes round.
  met_setup u_setup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pix_valid_i (pixel_i.valid),
    .pix_ready_o (pixel_i.ready),
    .pix_col_i   (pixel_i.pixel_col),
    .pix_row_i   (pixel_i.pixel_row),
    .pt_valid_o  (st_valid),
    .pt_take_i   (ld_take),
    .pt_o        (st_pt)
  );

  met_iter u_iter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pt_valid_i  (st_valid),
    .pt_take_o   (ld_take),
    .pt_i        (st_pt),
    .res_valid_o (res_valid),
    .res_ready_i (result_o.ready),
    .res_o       (res)
  );

  assign result_o.valid      = res_valid;
  assign result_o.iterations = res.iterations;
  assign result_o.inside_res = res.inside_res;
  assign result_o.red        = res.color[3*CHAN_W-1:2*CHAN_W];
  assign result_o.green      = res.color[2*CHAN_W-1:CHAN_W];
  assign result_o.blue       = res.color[CHAN_W-1:0];

  // The loop only loads a point that the setup pipeline actually presents.
  a_take_has_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_take |-> st_valid)
    else $error("escape loop loaded a slot without a point from setup");

  // A delivered count never exceeds the limit.
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.iterations <= cfg_q.max_iter))
    else $error("iteration count above the configured limit");

  // The interior flag agrees with the count.
  a_flag_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.inside_res == (result_o.iterations == cfg_q.max_iter)))
    else $error("interior flag disagrees with the iteration count");

  // Interior points are black.
  a_inside_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.inside_res) |->
      ((result_o.red == '0) && (result_o.green == '0) && (result_o.blue == '0)))
    else $error("interior point delivered with a nonzero color");

endmodule
